[hw/rtl/flux_reference_and_current_limit_top_assert.svh]
// Assertion macros for the checker file of the flux reference block.
// No dependencies; include by bare file name.
`ifndef FLUX_REFERENCE_AND_CURRENT_LIMIT_TOP_ASSERT_SVH
`define FLUX_REFERENCE_AND_CURRENT_LIMIT_TOP_ASSERT_SVH

// Implication checked only while out of reset.
`define FRCL_ASSERT_RST(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frcl assertion failed");

// Next-cycle implication checked only while out of reset.
`define FRCL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frcl assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define FRCL_ASSERT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frcl assertion failed");

`endif

[hw/rtl/frcl_pkg.sv]
// Package of the flux reference and current limit block: item types,
// register indexes, arithmetic constants and shared-unit control types.
// No dependencies.
package frcl_pkg;

    typedef struct packed {
        logic               steady_speed;
        logic               voltage_loop_on;
        logic signed [15:0] torque_ref;
        logic signed [15:0] iq_ref;
        logic signed [31:0] active_power;
        logic signed [31:0] reactive_power;
        logic signed [15:0] voltage_max;
        logic signed [15:0] voltage_out;
    } t_frcl_in;

    typedef struct packed {
        logic signed [15:0] id_reference;
        logic        [15:0] torque_constant;
        logic        [14:0] iq_limit;
        logic               power_save_active;
    } t_frcl_out;

    // shift-subtract unit control and status
    typedef struct packed {
        logic start;
        logic mode;
    } t_ds_ctl;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_ds_sts;

    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_ID   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_ID   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATED_TORQUE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PS_ENABLE    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PS_LEVEL     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_LIM_PCT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATED_CUR    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_IND      = 4'd7;

    localparam int MUL_W = 26;

    localparam logic signed [MUL_W-1:0] K_LOW_PCT  = 26'sd35;
    localparam logic signed [MUL_W-1:0] K_KI       = 26'sd660;
    localparam logic signed [MUL_W-1:0] K_FAST     = 26'sd4120;
    localparam logic signed [MUL_W-1:0] K_SLOW     = 26'sd103;
    localparam logic signed [MUL_W-1:0] K_LIM_SCL  = 26'sd563;
    // floor(2^31 / 100); error below one for operands under 2^24
    localparam logic signed [MUL_W-1:0] K_RECIP100 = 26'sd21474836;
    localparam logic [24:0]  K_HUNDRED   = 25'd100;
    localparam logic [7:0]   COUNT_LIMIT = 8'd250;
    localparam logic [15:0]  SAT_POS     = 16'd32767;
    localparam logic [15:0]  SAT_NEG_MAG = 16'd32768;
    localparam logic [15:0]  KT_MAX      = 16'hFFFF;

endpackage

[hw/rtl/flux_reference_and_current_limit_top.sv]
// Top level of the flux reference and current limit block: sequencer,
// state and configuration. Depends on frcl_pkg, frcl_mul, frcl_divsqrt.
//
// Use: one input item per control tick on i_in_data (i_in_valid, o_in_stall);
// one result item per input on o_out_data (o_out_valid, i_out_stall).
// An item is taken at an edge with valid high and stall low.
// Configuration: i_cfg_index / i_cfg_data written when i_cfg_valid and
// o_cfg_ready are high; o_cfg_ready is always high, unknown indexes are
// ignored. Write only while the block is idle.
// A result takes longer from the accepting edge to o_out_valid in power save
// mode than in normal mode, and is shorter when the power-save quotient overflows
// or its divisor is zero, or when the q-axis limit needs no square root.
// The time is set by the single shared 26x26 multiplier (one product a
// cycle, reused for every scaling step) and the shift-subtract unit (17 steps
// for the power-save quotient, 16 for the q-axis limit square root). One item
// is worked on at a time: o_in_stall is high from acceptance until the
// sequencer is back at idle, so a new item is not taken before the last one
// has reached the output register.
// A finished result sits in the output register; while the receiver stalls,
// the next item may still be accepted and computed, and it waits at the end.
// Reset (synchronous, active low) restores register defaults, clears the
// integrator, light-load counter and save mode, and sets the d-axis filter to
// the default nominal current.
module flux_reference_and_current_limit_top import frcl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_frcl_in             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_frcl_out            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // sequencer steps
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_TL_MUL  = 5'd1;
    localparam logic [4:0] S_TL_X    = 5'd2;
    localparam logic [4:0] S_D100_A  = 5'd3;
    localparam logic [4:0] S_D100_B  = 5'd4;
    localparam logic [4:0] S_HYST    = 5'd5;
    localparam logic [4:0] S_PI_MUL  = 5'd6;
    localparam logic [4:0] S_PI_INT  = 5'd7;
    localparam logic [4:0] S_PI_REF  = 5'd8;
    localparam logic [4:0] S_FF_MUL  = 5'd9;
    localparam logic [4:0] S_FF_ADD  = 5'd10;
    localparam logic [4:0] S_PS_MUL  = 5'd11;
    localparam logic [4:0] S_PS_NUM  = 5'd12;
    localparam logic [4:0] S_PS_DIV  = 5'd13;
    localparam logic [4:0] S_PS_PCT  = 5'd14;
    localparam logic [4:0] S_PS_PX   = 5'd15;
    localparam logic [4:0] S_PS_CLIP = 5'd16;
    localparam logic [4:0] S_PS_ADD  = 5'd17;
    localparam logic [4:0] S_KT_MUL  = 5'd18;
    localparam logic [4:0] S_KT_SAT  = 5'd19;
    localparam logic [4:0] S_LIM_MUL = 5'd20;
    localparam logic [4:0] S_LIM_B   = 5'd21;
    localparam logic [4:0] S_LIM_C   = 5'd22;
    localparam logic [4:0] S_LIM_D   = 5'd23;
    localparam logic [4:0] S_LIM_E   = 5'd24;
    localparam logic [4:0] S_LIM_F   = 5'd25;
    localparam logic [4:0] S_SQ_WAIT = 5'd26;
    localparam logic [4:0] S_DONE    = 5'd27;

    // configuration registers
    logic [14:0] r_nominal_id;
    logic [14:0] r_minimum_id;
    logic [14:0] r_rated_torque;
    logic        r_ps_enable;
    logic [6:0]  r_ps_level;
    logic [7:0]  r_cur_lim_pct;
    logic [14:0] r_rated_cur;
    logic [15:0] r_mag_ind;

    // block state
    logic signed [31:0] r_integral;
    logic               r_clamp;
    logic [7:0]         r_count;
    logic               r_save;
    logic [31:0]        r_id_filter;

    // sequencer and scratch registers
    logic [4:0]         r_state, n_state;
    logic [4:0]         r_ret;
    t_frcl_in           r_in;
    logic [23:0]        r_x;
    logic [17:0]        r_q;
    logic signed [15:0] r_err;
    logic [14:0]        r_ref;
    logic               r_neg;
    logic [15:0]        r_t;
    logic [15:0]        r_kt;
    logic [29:0]        r_sq;
    logic [14:0]        r_iqlim;
    t_frcl_out          r_out;
    logic               r_ovalid;

    // shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    t_ds_ctl                   ds_ctl;
    t_ds_sts                   ds_sts;
    logic [33:0]               ds_a;
    logic [16:0]               ds_b;
    logic [16:0]               ds_res;

    // datapath terms
    logic signed [15:0] hi;
    logic [17:0]        q_est;
    logic [24:0]        q100;
    logic [24:0]        rem100;
    logic [17:0]        q_fix;
    logic [16:0]        tq_low, tq_high, tq_mag;
    logic [16:0]        verr_w;
    logic signed [15:0] verr;
    logic [32:0]        int_sum;
    logic signed [31:0] int_sat;
    logic signed [18:0] pi_r;
    logic signed [16:0] ff_diff;
    logic [14:0]        ps_min;
    logic signed [16:0] ps_diff;
    logic signed [34:0] num;
    logic signed [16:0] den;
    logic [34:0]        num_abs;
    logic [16:0]        den_abs;
    logic [15:0]        t_sat;
    logic [14:0]        lim;
    logic               lim_low;
    logic signed [31:0] rad;
    logic [18:0]        kt_raw;
    logic               out_free;

    assign hi       = $signed(r_id_filter[31:16]);
    assign out_free = !r_ovalid || !i_out_stall;

    frcl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    frcl_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ds_ctl),
        .i_a     (ds_a),
        .i_b     (ds_b),
        .o_sts   (ds_sts),
        .o_res   (ds_res)
    );

    // arithmetic around the shared units
    always_comb begin
        // divide by 100: reciprocal estimate, then one correction
        q_est  = mul_p[48:31];
        q100   = {1'b0, q_est, 6'd0} + {2'b0, q_est, 5'd0} + {5'b0, q_est, 2'd0};
        rem100 = {1'b0, r_x} - q100;
        q_fix  = (rem100 >= K_HUNDRED) ? q_est + 18'd1 : q_est;

        tq_low  = r_q[16:0];
        tq_high = {3'b000, r_rated_torque[14:1]};
        tq_mag  = r_in.torque_ref[15] ? 17'd0 - {1'b1, r_in.torque_ref}
                                      : {1'b0, r_in.torque_ref};

        verr_w = {r_in.voltage_max[15], r_in.voltage_max}
               - {r_in.voltage_out[15], r_in.voltage_out};
        if (verr_w[16] != verr_w[15]) begin
            verr = verr_w[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            verr = $signed(verr_w[15:0]);
        end

        int_sum = {r_integral[31], r_integral} + mul_p[32:0];
        if (int_sum[32] != int_sum[31]) begin
            int_sat = int_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            int_sat = $signed(int_sum[31:0]);
        end

        pi_r = $signed({4'b0000, r_nominal_id})
             + $signed({{5{r_err[15]}}, r_err[15:2]})
             + $signed({{3{r_integral[31]}}, r_integral[31:16]});

        ff_diff = $signed({2'b00, r_ref}) - $signed({hi[15], hi});

        ps_min  = ({1'b0, r_q} < {4'b0000, r_ref}) ? r_q[14:0] : r_ref;
        ps_diff = $signed({2'b00, ps_min}) - $signed({hi[15], hi});

        num     = mul_p[34:0];
        den     = r_in.reactive_power[31:15];
        num_abs = num[34] ? 35'd0 - num : num;
        den_abs = den[16] ? 17'd0 - den : den;

        if (ds_sts.ovf) begin
            t_sat = r_neg ? SAT_NEG_MAG : SAT_POS;
        end else if (r_neg) begin
            t_sat = (ds_res > {1'b0, SAT_NEG_MAG}) ? SAT_NEG_MAG : ds_res[15:0];
        end else begin
            t_sat = (ds_res > {1'b0, SAT_POS}) ? SAT_POS : ds_res[15:0];
        end

        lim     = (r_q >= 18'd32767) ? 15'h7FFF : r_q[14:0];
        lim_low = $signed({3'b000, lim}) < $signed({{2{hi[15]}}, hi});
        rad     = $signed({2'b00, r_sq}) - $signed({1'b0, mul_p[30:0]});
        kt_raw  = mul_p[31:13];
    end

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_TL_MUL: begin
                mul_a = {11'd0, r_rated_torque};
                mul_b = K_LOW_PCT;
            end
            S_D100_A: begin
                mul_a = {2'b00, r_x};
                mul_b = K_RECIP100;
            end
            S_PI_MUL: begin
                mul_a = {{10{r_err[15]}}, r_err};
                mul_b = K_KI;
            end
            S_FF_MUL: begin
                mul_a = {{9{ff_diff[16]}}, ff_diff};
                mul_b = K_FAST;
            end
            S_PS_MUL: begin
                mul_a = {{10{r_in.iq_ref[15]}}, r_in.iq_ref};
                mul_b = {{7{r_in.active_power[31]}}, r_in.active_power[31:13]};
            end
            S_PS_PCT: begin
                mul_a = {10'd0, r_t};
                mul_b = {19'd0, r_ps_level};
            end
            S_PS_CLIP: begin
                mul_a = {{9{ps_diff[16]}}, ps_diff};
                mul_b = K_SLOW;
            end
            S_KT_MUL: begin
                mul_a = hi[15] ? '0 : {{10{1'b0}}, hi};
                mul_b = {10'd0, r_mag_ind};
            end
            S_LIM_MUL: begin
                mul_a = {18'd0, r_cur_lim_pct};
                mul_b = K_LIM_SCL;
            end
            S_LIM_B: begin
                mul_a = {11'd0, r_rated_cur};
                mul_b = {17'd0, mul_p[17:9]};
            end
            S_LIM_D: begin
                mul_a = {11'd0, lim};
                mul_b = {11'd0, lim};
            end
            S_LIM_E: begin
                mul_a = {{10{hi[15]}}, hi};
                mul_b = {{10{hi[15]}}, hi};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shift-subtract unit requests
    always_comb begin
        ds_ctl.start = 1'b0;
        ds_ctl.mode  = MODE_DIV;
        ds_a         = num_abs[33:0];
        ds_b         = den_abs;
        if (r_state == S_PS_NUM && den != 17'sd0) begin
            ds_ctl.start = 1'b1;
        end else if (r_state == S_LIM_F && rad > 32'sd0) begin
            ds_ctl.start = 1'b1;
            ds_ctl.mode  = MODE_SQRT;
            ds_a         = {2'b00, rad};
        end
    end

    // next step
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_TL_MUL;
            S_TL_MUL:  n_state = S_TL_X;
            S_TL_X:    n_state = S_D100_A;
            S_D100_A:  n_state = S_D100_B;
            S_D100_B:  n_state = r_ret;
            S_HYST:    n_state = S_PI_MUL;
            S_PI_MUL:  n_state = S_PI_INT;
            S_PI_INT:  n_state = S_PI_REF;
            S_PI_REF:  n_state = r_save ? S_PS_MUL : S_FF_MUL;
            S_FF_MUL:  n_state = S_FF_ADD;
            S_FF_ADD:  n_state = S_KT_MUL;
            S_PS_MUL:  n_state = S_PS_NUM;
            S_PS_NUM:  n_state = (den == 17'sd0) ? S_PS_PCT : S_PS_DIV;
            S_PS_DIV:  if (ds_sts.done) n_state = S_PS_PCT;
            S_PS_PCT:  n_state = S_PS_PX;
            S_PS_PX:   n_state = S_D100_A;
            S_PS_CLIP: n_state = S_PS_ADD;
            S_PS_ADD:  n_state = S_KT_MUL;
            S_KT_MUL:  n_state = S_KT_SAT;
            S_KT_SAT:  n_state = S_LIM_MUL;
            S_LIM_MUL: n_state = S_LIM_B;
            S_LIM_B:   n_state = S_LIM_C;
            S_LIM_C:   n_state = S_D100_A;
            S_LIM_D:   n_state = lim_low ? S_DONE : S_LIM_E;
            S_LIM_E:   n_state = S_LIM_F;
            S_LIM_F:   n_state = (rad > 32'sd0) ? S_SQ_WAIT : S_DONE;
            S_SQ_WAIT: if (ds_sts.done) n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal_id   <= 15'd8192;
            r_minimum_id   <= 15'd8192;
            r_rated_torque <= 15'd16384;
            r_ps_enable    <= 1'b0;
            r_ps_level     <= 7'd100;
            r_cur_lim_pct  <= 8'd150;
            r_rated_cur    <= 15'd16384;
            r_mag_ind      <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NOMINAL_ID:   r_nominal_id   <= i_cfg_data[14:0];
                REG_MINIMUM_ID:   r_minimum_id   <= i_cfg_data[14:0];
                REG_RATED_TORQUE: r_rated_torque <= i_cfg_data[14:0];
                REG_PS_ENABLE:    r_ps_enable    <= i_cfg_data[0];
                REG_PS_LEVEL:     r_ps_level     <= i_cfg_data[6:0];
                REG_CUR_LIM_PCT:  r_cur_lim_pct  <= i_cfg_data[7:0];
                REG_RATED_CUR:    r_rated_cur    <= i_cfg_data[14:0];
                REG_MAG_IND:      r_mag_ind      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, state and scratch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_HYST;
            r_integral  <= '0;
            r_clamp     <= 1'b0;
            r_count     <= '0;
            r_save      <= 1'b0;
            r_id_filter <= {16'd8192, 16'd0};
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new result replaces the old one only once it has been taken
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: if (i_in_valid) r_in <= i_in_data;
                S_TL_X: begin
                    r_x   <= mul_p[23:0];
                    r_ret <= S_HYST;
                end
                S_D100_B: r_q <= q_fix;
                S_HYST: begin
                    r_err <= verr;
                    if (r_ps_enable && r_in.steady_speed) begin
                        if (tq_mag < tq_low) begin
                            if (r_count <= COUNT_LIMIT) r_count <= r_count + 8'd1;
                            else r_save <= 1'b1;
                        end else if (tq_mag > tq_high) begin
                            r_save  <= 1'b0;
                            r_count <= '0;
                        end
                    end else begin
                        r_save  <= 1'b0;
                        r_count <= '0;
                    end
                end
                S_PI_INT: begin
                    if (!r_in.voltage_loop_on) r_integral <= '0;
                    else if (!r_clamp) r_integral <= int_sat;
                end
                S_PI_REF: begin
                    if (r_in.voltage_loop_on) begin
                        if (pi_r >= $signed({4'b0000, r_nominal_id})) begin
                            r_ref   <= r_nominal_id;
                            r_clamp <= 1'b1;
                        end else if (pi_r < $signed({4'b0000, r_minimum_id})) begin
                            r_ref   <= r_minimum_id;
                            r_clamp <= 1'b1;
                        end else begin
                            r_ref   <= pi_r[14:0];
                            r_clamp <= 1'b0;
                        end
                    end else begin
                        r_ref <= r_nominal_id;
                    end
                end
                S_FF_ADD: r_id_filter <= r_id_filter + mul_p[31:0];
                S_PS_NUM: begin
                    r_neg <= num[34] ^ den[16];
                    if (den == 17'sd0) r_t <= SAT_POS;
                end
                S_PS_DIV: if (ds_sts.done) r_t <= t_sat;
                S_PS_PX: begin
                    r_x   <= mul_p[23:0];
                    r_ret <= S_PS_CLIP;
                end
                S_PS_ADD: r_id_filter <= r_id_filter + mul_p[31:0];
                S_KT_SAT: r_kt <= (kt_raw > {3'b000, KT_MAX}) ? KT_MAX : kt_raw[15:0];
                S_LIM_C: begin
                    r_x   <= mul_p[23:0];
                    r_ret <= S_LIM_D;
                end
                S_LIM_D: if (lim_low) r_iqlim <= '0;
                S_LIM_E: r_sq <= mul_p[29:0];
                S_LIM_F: if (rad <= 32'sd0) r_iqlim <= '0;
                S_SQ_WAIT: if (ds_sts.done) r_iqlim <= ds_res[14:0];
                S_DONE: begin
                    if (out_free) begin
                        r_out.id_reference      <= hi;
                        r_out.torque_constant   <= r_kt;
                        r_out.iq_limit          <= r_iqlim;
                        r_out.power_save_active <= r_save;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

[hw/rtl/frcl_mul.sv]
// Shared signed multiplier with registered product.
// Depends on frcl_pkg.
module frcl_mul import frcl_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_W-1:0]   i_a,
    input  logic signed [MUL_W-1:0]   i_b,
    output logic signed [2*MUL_W-1:0] o_p
);

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[hw/rtl/frcl_divsqrt.sv]
// Shared restoring shift-subtract unit: 17-bit quotient division with
// overflow flag, or 16-step integer square root. Depends on frcl_pkg.
module frcl_divsqrt import frcl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ds_ctl     i_ctl,
    input  logic [33:0] i_a,
    input  logic [16:0] i_b,
    output t_ds_sts     o_sts,
    output logic [16:0] o_res
);

    logic        r_busy;
    logic        r_mode;
    logic [4:0]  r_cnt;
    logic [17:0] r_rem;
    logic [16:0] r_res;
    logic [33:0] r_sh;
    logic [16:0] r_b;
    logic        r_done;
    logic        r_ovf;

    logic [19:0] cand_x;
    logic [19:0] cand_y;
    logic [20:0] diff;
    logic        ge;

    // one shared subtractor for both modes
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            cand_x = {r_rem, r_sh[33:32]};
            cand_y = {2'b00, r_res[15:0], 2'b01};
        end else begin
            cand_x = {2'b00, r_rem[16:0], r_sh[33]};
            cand_y = {3'b000, r_b};
        end
        diff = {1'b0, cand_x} - {1'b0, cand_y};
        ge   = ~diff[20];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
            r_mode <= MODE_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_mode <= i_ctl.mode;
                r_b    <= i_b;
                r_res  <= '0;
                r_ovf  <= 1'b0;
                if (i_ctl.mode == MODE_SQRT) begin
                    r_rem  <= '0;
                    r_sh   <= {i_a[31:0], 2'b00};
                    r_cnt  <= 5'd16;
                    r_busy <= 1'b1;
                end else if (i_a[33:17] >= i_b) begin
                    // quotient needs more than 17 bits
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {1'b0, i_a[33:17]};
                    r_sh   <= {i_a[16:0], 17'd0};
                    r_cnt  <= 5'd17;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[17:0] : cand_x[17:0];
                r_res <= {r_res[15:0], ge};
                r_sh  <= (r_mode == MODE_SQRT) ? {r_sh[31:0], 2'b00} : {r_sh[32:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_res      = r_res;

endmodule

[hw/rtl/frcl_checker.sv]
// Port-level checker for the flux reference block, bound to the top level.
// Depends on frcl_pkg and flux_reference_and_current_limit_top_assert.svh.
`include "flux_reference_and_current_limit_top_assert.svh"

module frcl_checker import frcl_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_frcl_out            o_out_data
);

    // a waiting result stays offered
    `FRCL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // and its payload holds
    `FRCL_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
                     $stable(o_out_data))

    // one item at a time: the input side closes right after acceptance
    `FRCL_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // no result straight out of reset
    `FRCL_ASSERT_ALL(a_rst_quiet, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind flux_reference_and_current_limit_top frcl_checker u_frcl_checker (.*);

[tb/sv/tb.sv]
// Testbench of flux_reference_and_current_limit_top: random and directed control ticks,
// a bit-exact predictor of the d-axis reference, torque constant and q-axis limit.
// Depends on frcl_pkg and the RTL of the block.
module tb import frcl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // predictor: configuration and loop state of the block
    class flux_scoreboard;
        int unsigned nom_id, min_id, rated_tq, ps_en, ps_pct, lim_pct, rated_cur, l_mag;
        int signed   v_int;
        bit          clamp, save;
        int unsigned ll_count;
        bit [31:0]   id_filt;
        t_frcl_out   pending[$];
        int          errors;
        int          checked;
        int          saves;

        function void reset_state();
            nom_id = 8192; min_id = 8192; rated_tq = 16384; ps_en = 0;
            ps_pct = 100; lim_pct = 150; rated_cur = 16384; l_mag = 256;
            v_int = 0; clamp = 0; save = 0; ll_count = 0;
            id_filt = 32'(nom_id) << 16;
            pending.delete();
            errors = 0; checked = 0; saves = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                REG_NOMINAL_ID:   nom_id    = d[14:0];
                REG_MINIMUM_ID:   min_id    = d[14:0];
                REG_RATED_TORQUE: rated_tq  = d[14:0];
                REG_PS_ENABLE:    ps_en     = d[0];
                REG_PS_LEVEL:     ps_pct    = d[6:0];
                REG_CUR_LIM_PCT:  lim_pct   = d[7:0];
                REG_RATED_CUR:    rated_cur = d[14:0];
                REG_MAG_IND:      l_mag     = d[15:0];
                default: ;
            endcase
        endfunction

        // integer square root rounded down
        function automatic longint root_floor(longint x);
            longint r, b;
            r = 0; b = 64'd1 << 30;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_input(t_frcl_in it);
            longint tq, err, r, rf, hi, idv, q_lo, q_hi, mag, num, den, quo, t, k, lim, rad;
            t_frcl_out o;
            tq = it.torque_ref;
            rf = nom_id;
            q_lo = (longint'(rated_tq) * 35) / 100;
            q_hi = (longint'(rated_tq) * 50) / 100;
            if (ps_en != 0 && it.steady_speed) begin
                mag = tq < 0 ? -tq : tq;
                if (mag < q_lo) begin
                    if (ll_count <= 250) ll_count++;
                    else save = 1;
                end else if (mag > q_hi) begin
                    save = 0; ll_count = 0;
                end
            end else begin
                save = 0; ll_count = 0;
            end
            if (it.voltage_loop_on) begin
                err = longint'(it.voltage_max) - longint'(it.voltage_out);
                if (err > 32767) err = 32767;
                if (err < -32768) err = -32768;
                if (!clamp) begin
                    r = longint'(v_int) + err * 660;
                    if (r > 64'sd2147483647) r = 64'sd2147483647;
                    if (r < -64'sd2147483648) r = -64'sd2147483648;
                    v_int = int'(r);
                end
                // >>> on signed longint floors, as required
                r = longint'(nom_id) + ((err * 256) >>> 10) + (longint'(v_int) >>> 16);
                if (r >= longint'(nom_id)) begin
                    r = nom_id; clamp = 1;
                end else if (r < longint'(min_id)) begin
                    r = min_id; clamp = 1;
                end else begin
                    clamp = 0;
                end
                rf = r;
            end else begin
                v_int = 0;
            end
            hi = longint'($signed(id_filt[31:16]));
            if (!save) begin
                id_filt = id_filt + 32'((rf - hi) * 4120);
            end else begin
                num = longint'(it.iq_ref) * (longint'(it.active_power) >>> 13);
                den = longint'(it.reactive_power) >>> 15;
                if (den == 0) quo = 32767;
                else begin
                    quo = num / den;
                    if (quo > 32767) quo = 32767;
                    if (quo < -32768) quo = -32768;
                end
                t = quo < 0 ? -quo : quo;
                t = (t * longint'(ps_pct)) / 100;
                if (t > rf) t = rf;
                id_filt = id_filt + 32'((t - hi) * 103);
            end
            idv = longint'($signed(id_filt[31:16]));
            k = idv < 0 ? 0 : ((longint'(l_mag) * idv) >> 13);
            if (k > 65535) k = 65535;
            lim = (longint'(rated_cur) * ((longint'(lim_pct) * 563) >> 9)) / 100;
            if (lim >= 32767) lim = 32767;
            o.id_reference = 16'(idv);
            o.torque_constant = 16'(k);
            if (lim < idv) o.iq_limit = '0;
            else begin
                rad = lim * lim - idv * idv;
                o.iq_limit = rad <= 0 ? 15'd0 : 15'(root_floor(rad));
            end
            o.power_save_active = save;
            if (save) saves++;
            pending.push_back(o);
        endfunction

        task report_mismatch(string what, longint exp_v, longint got_v);
            errors++;
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        endtask

        task check_result(t_frcl_out got);
            t_frcl_out e;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result item", 0, longint'(got));
                return;
            end
            e = pending.pop_front();
            if (got.id_reference !== e.id_reference)
                report_mismatch("id_reference", e.id_reference, got.id_reference);
            if (got.torque_constant !== e.torque_constant)
                report_mismatch("torque_constant", e.torque_constant, got.torque_constant);
            if (got.iq_limit !== e.iq_limit)
                report_mismatch("iq_limit", e.iq_limit, got.iq_limit);
            if (got.power_save_active !== e.power_save_active)
                report_mismatch("power_save_active", e.power_save_active,
                                got.power_save_active);
        endtask
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    t_frcl_in             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    t_frcl_out            out_data;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    flux_scoreboard sb;
    int  send_idle_pct = 0;  // chance the sender leaves a gap, per cycle
    int  recv_stall_pct = 0; // chance the receiver stalls, per cycle
    int  n_items = 0;
    int  quiet = 0;          // cycles without any accepted item
    localparam int WATCHDOG = 20000;

    always #5 clk = ~clk;

    flux_reference_and_current_limit_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // receiver: random stall, check every accepted result item
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on lack of progress
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("watchdog expired with %0d items pending", sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // wait for all results, then let the sequencer settle before any write
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // valid stays high between back-to-back items; drain() drops it
    task automatic send_item(t_frcl_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(it);
        n_items++;
    endtask

    function automatic t_frcl_in rand_item(bit light);
        t_frcl_in it;
        it.steady_speed    = ($urandom_range(9) != 0);
        it.voltage_loop_on = 1'($urandom_range(1));
        it.torque_ref      = light ? 16'($signed($urandom_range(4000)) - 2000) : 16'($urandom);
        it.iq_ref          = 16'($urandom);
        it.active_power    = $urandom;
        it.reactive_power  = ($urandom_range(7) == 0) ? 32'($urandom_range(65535)) - 32768
                                                      : 32'($urandom);
        it.voltage_max     = 16'($urandom);
        it.voltage_out     = ($urandom_range(1)) ? it.voltage_max - 16'($urandom_range(600))
                                                 : 16'($urandom);
        return it;
    endfunction

    task automatic random_phase(int count, bit light);
        repeat (count) send_item(rand_item(light));
    endtask

    task automatic set_regs(int n, int m, int rt, int en, int lvl, int lp, int rc, int lm);
        cfg_write(REG_NOMINAL_ID, 16'(n));
        cfg_write(REG_MINIMUM_ID, 16'(m));
        cfg_write(REG_RATED_TORQUE, 16'(rt));
        cfg_write(REG_PS_ENABLE, 16'(en));
        cfg_write(REG_PS_LEVEL, 16'(lvl));
        cfg_write(REG_CUR_LIM_PCT, 16'(lp));
        cfg_write(REG_RATED_CUR, 16'(rc));
        cfg_write(REG_MAG_IND, 16'(lm));
    endtask

    initial begin
        t_frcl_in it;
        sb = new();
        sb.reset_state();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, loop off/on, saturation of the error
        it = '0;
        send_item(it);
        it.voltage_loop_on = 1; it.voltage_max = 16'sh7FFF; it.voltage_out = 16'sh8000;
        send_item(it);
        it.voltage_max = 16'sh8000; it.voltage_out = 16'sh7FFF;
        repeat (4) send_item(it);
        it = '1;
        send_item(it);
        it.torque_ref = 16'sh8000; it.iq_ref = 16'sh8000;
        it.active_power = 32'sh80000000; it.reactive_power = 32'sh7FFFFFFF;
        send_item(it);
        drain();

        // inverted clamps, unknown index, extreme inductance and limit
        set_regs(1000, 20000, 32767, 1, 100, 250, 32767, 65535);
        cfg_write(4'd12, 16'hFFFF);
        it = '0; it.voltage_loop_on = 1; it.voltage_max = 16'sh8000;
        send_item(it);
        it.voltage_loop_on = 0;
        send_item(it);
        // light load toward power save, zero divisor
        it = '0; it.steady_speed = 1; it.torque_ref = 16'sd5;
        it.iq_ref = 16'sh7FFF; it.active_power = 32'sh7FFFFFFF; it.reactive_power = 32'd100;
        repeat (12) send_item(it);
        drain();

        // zero-value extremes of every register
        set_regs(0, 0, 0, 0, 0, 0, 0, 0);
        random_phase(20, 0);
        drain();

        // light load toward power save, which needs about 252 steady light-load ticks in a row
        set_regs(12000, 3000, 20000, 1, 60, 150, 16384, 300);
        send_idle_pct = 35; recv_stall_pct = 47;
        random_phase(300, 1);
        drain();

        set_regs(32767, 0, 16384, 1, 100, 200, 20000, 256);
        send_idle_pct = 47; recv_stall_pct = 35;
        random_phase(150, 0);
        drain();

        set_regs(8192, 8192, 16384, 0, 100, 150, 16384, 256);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_phase(150, 0);
        drain();
        repeat (100) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d in power save, %0d mismatches",
                 n_items, sb.checked, sb.saves, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
